// File: rtl/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared widths, constants and transaction types for the triangle surface
// gradient pipeline.
// ----------------------------------------------------------------------------
package tsg_pkg;

	// fixed point format of coordinates, potentials and gradient
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 32;

	// vertex and potential differences
	localparam int D_W  = IN_W + 1;
	// cross product terms and normal components
	localparam int P_W  = 2 * D_W;
	localparam int N_W  = P_W + 1;

	// split of a normal component into a signed high and unsigned low part
	localparam int LO_W = 32;
	localparam int NH_W = N_W - LO_W;
	localparam int HH_W = 2 * NH_W;
	localparam int HL_W = NH_W + LO_W + 1;
	localparam int LL_W = 2 * LO_W;

	// squared normal length
	localparam int DEN_W = 2 * N_W;
	localparam int SQ_W  = DEN_W + 2;

	// normal times edge partial products and full value
	localparam int NX_HI_W = NH_W + D_W;
	localparam int NX_LO_W = LO_W + 1 + D_W;
	localparam int NB_W    = N_W + D_W + 1;

	// potential difference times (N x edge), cut in three chunks
	localparam int BH_W  = NB_W - 2 * LO_W;
	localparam int PH_W  = BH_W + D_W;
	localparam int PL_W  = LO_W + 1 + D_W;
	localparam int NUM_W = NB_W + D_W + 1;

	// divider
	localparam int MAG_W = NUM_W + FRAC_BITS;
	localparam int Q_W   = IN_W + 1;
	localparam int CMP_W = ((MAG_W > DEN_W + Q_W) ? MAG_W : DEN_W + Q_W) + 1;

	// register stages: geometry, projection, divider
	localparam int PIPE_LAT = 3 + 6 + Q_W + 3;

	// saturation limits on the quotient magnitude and the result
	localparam logic [Q_W-1:0] LIM_POS = Q_W'((64'd1 << (IN_W - 1)) - 64'd1);
	localparam logic [Q_W-1:0] LIM_NEG = Q_W'(64'd1 << (IN_W - 1));
	localparam logic signed [IN_W-1:0] RES_MAX = IN_W'((64'd1 << (IN_W - 1)) - 64'd1);
	localparam logic signed [IN_W-1:0] RES_MIN = IN_W'(64'd1 << (IN_W - 1));

	// cyclic neighbours of a vector component
	localparam int unsigned NXT [3] = '{1, 2, 0};
	localparam int unsigned PRV [3] = '{2, 0, 1};

	// input transaction
	typedef struct packed {
		logic signed [IN_W-1:0] a_x;
		logic signed [IN_W-1:0] a_y;
		logic signed [IN_W-1:0] a_z;
		logic signed [IN_W-1:0] b_x;
		logic signed [IN_W-1:0] b_y;
		logic signed [IN_W-1:0] b_z;
		logic signed [IN_W-1:0] c_x;
		logic signed [IN_W-1:0] c_y;
		logic signed [IN_W-1:0] c_z;
		logic signed [IN_W-1:0] pot_a;
		logic signed [IN_W-1:0] pot_b;
		logic signed [IN_W-1:0] pot_c;
	} item_t;

	// result transaction
	typedef struct packed {
		logic signed [IN_W-1:0] grad_x;
		logic signed [IN_W-1:0] grad_y;
		logic signed [IN_W-1:0] grad_z;
		logic                   degenerate;
		logic                   saturated;
	} result_t;

	// geometry stage to projection stage
	typedef struct packed {
		logic [2:0][N_W-1:0] n;
		logic [2:0][D_W-1:0] ab;
		logic [2:0][D_W-1:0] bc;
		logic [D_W-1:0]      dpc;
		logic [D_W-1:0]      dpa;
	} geo_t;

	// projection stage to divider
	typedef struct packed {
		logic [2:0][NUM_W-1:0] num;
		logic [DEN_W-1:0]      den;
		logic                  dz;
	} quo_t;

endpackage

// File: rtl/tsg_geom.sv
// ----------------------------------------------------------------------------
// tsg_geom
// Edge vectors, potential differences and the triangle normal N = ab x bc,
// three register stages.
// ----------------------------------------------------------------------------
module tsg_geom (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  tsg_pkg::item_t        item,
	output logic                  geo_vld,
	output tsg_pkg::geo_t         geo
);

	logic signed [tsg_pkg::IN_W-1:0] va [3];
	logic signed [tsg_pkg::IN_W-1:0] vb [3];
	logic signed [tsg_pkg::IN_W-1:0] vc [3];

	logic vld_s1, vld_s2, vld_s3;

	logic signed [tsg_pkg::D_W-1:0] ab_s1 [3];
	logic signed [tsg_pkg::D_W-1:0] bc_s1 [3];
	logic signed [tsg_pkg::D_W-1:0] dpc_s1, dpa_s1;

	logic signed [tsg_pkg::P_W-1:0] pa_s2 [3];
	logic signed [tsg_pkg::P_W-1:0] pb_s2 [3];
	logic signed [tsg_pkg::D_W-1:0] ab_s2 [3];
	logic signed [tsg_pkg::D_W-1:0] bc_s2 [3];
	logic signed [tsg_pkg::D_W-1:0] dpc_s2, dpa_s2;

	logic signed [tsg_pkg::N_W-1:0] n_s3 [3];
	logic signed [tsg_pkg::D_W-1:0] ab_s3 [3];
	logic signed [tsg_pkg::D_W-1:0] bc_s3 [3];
	logic signed [tsg_pkg::D_W-1:0] dpc_s3, dpa_s3;

	// vertices as component arrays
	always_comb begin
		va[0] = item.a_x; va[1] = item.a_y; va[2] = item.a_z;
		vb[0] = item.b_x; vb[1] = item.b_y; vb[2] = item.b_z;
		vc[0] = item.c_x; vc[1] = item.c_y; vc[2] = item.c_z;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: differences, stage 2: cross products, stage 3: normal
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ab_s1[i] <= tsg_pkg::D_W'(vb[i]) - tsg_pkg::D_W'(va[i]);
			bc_s1[i] <= tsg_pkg::D_W'(vc[i]) - tsg_pkg::D_W'(vb[i]);
		end
		dpc_s1 <= tsg_pkg::D_W'(item.pot_c) - tsg_pkg::D_W'(item.pot_b);
		dpa_s1 <= tsg_pkg::D_W'(item.pot_a) - tsg_pkg::D_W'(item.pot_b);

		for (int i = 0; i < 3; i++) begin
			pa_s2[i] <= ab_s1[tsg_pkg::NXT[i]] * bc_s1[tsg_pkg::PRV[i]];
			pb_s2[i] <= ab_s1[tsg_pkg::PRV[i]] * bc_s1[tsg_pkg::NXT[i]];
			ab_s2[i] <= ab_s1[i];
			bc_s2[i] <= bc_s1[i];
		end
		dpc_s2 <= dpc_s1;
		dpa_s2 <= dpa_s1;

		for (int i = 0; i < 3; i++) begin
			n_s3[i]  <= tsg_pkg::N_W'(pa_s2[i]) - tsg_pkg::N_W'(pb_s2[i]);
			ab_s3[i] <= ab_s2[i];
			bc_s3[i] <= bc_s2[i];
		end
		dpc_s3 <= dpc_s2;
		dpa_s3 <= dpa_s2;
	end

	// hand over to the projection stages
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			geo.n[i]  = n_s3[i];
			geo.ab[i] = ab_s3[i];
			geo.bc[i] = bc_s3[i];
		end
		geo.dpc = dpc_s3;
		geo.dpa = dpa_s3;
	end

	assign geo_vld = vld_s3;

endmodule

// File: rtl/tsg_proj.sv
// ----------------------------------------------------------------------------
// tsg_proj
// Squared normal length and the gradient numerator
// (pc-pb)(N x ab) + (pa-pb)(N x bc), built from narrow partial products
// over six register stages.
// ----------------------------------------------------------------------------
module tsg_proj (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           geo_vld,
	input  tsg_pkg::geo_t  geo,
	output logic           quo_vld,
	output tsg_pkg::quo_t  quo
);

	logic signed [tsg_pkg::N_W-1:0]  n_c  [3];
	logic signed [tsg_pkg::NH_W-1:0] nh_c [3];
	logic signed [tsg_pkg::LO_W:0]   nl_c [3];
	logic signed [tsg_pkg::D_W-1:0]  ab_c [3];
	logic signed [tsg_pkg::D_W-1:0]  bc_c [3];

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// stage 4: partial products
	logic signed [tsg_pkg::HH_W-1:0]    hh_s4 [3];
	logic signed [tsg_pkg::HL_W-1:0]    hl_s4 [3];
	logic        [tsg_pkg::LL_W-1:0]    ll_s4 [3];
	logic signed [tsg_pkg::NX_HI_W-1:0] xh_s4 [3][4];
	logic signed [tsg_pkg::NX_LO_W-1:0] xl_s4 [3][4];
	logic signed [tsg_pkg::D_W-1:0]     dpc_s4, dpa_s4;

	// stage 5: full squares and full products
	logic signed [tsg_pkg::SQ_W-1:0] sq_c [3];
	logic signed [tsg_pkg::NB_W-1:0] pf_c [3][4];
	logic        [tsg_pkg::DEN_W-1:0] sq_s5 [3];
	logic signed [tsg_pkg::NB_W-1:0]  pf_s5 [3][4];
	logic signed [tsg_pkg::D_W-1:0]   dpc_s5, dpa_s5;

	// stage 6: denominator and N x ab, N x bc
	logic        [tsg_pkg::DEN_W-1:0] den_s6;
	logic signed [tsg_pkg::NB_W-1:0]  nab_s6 [3];
	logic signed [tsg_pkg::NB_W-1:0]  nbc_s6 [3];
	logic signed [tsg_pkg::D_W-1:0]   dpc_s6, dpa_s6;

	// stage 7: chunked products with the potential differences
	logic signed [tsg_pkg::BH_W-1:0]  bh_c [3][2];
	logic signed [tsg_pkg::LO_W:0]    bm_c [3][2];
	logic signed [tsg_pkg::LO_W:0]    bl_c [3][2];
	logic signed [tsg_pkg::D_W-1:0]   dp_c [2];
	logic signed [tsg_pkg::PH_W-1:0]  ph_s7 [3][2];
	logic signed [tsg_pkg::PL_W-1:0]  pm_s7 [3][2];
	logic signed [tsg_pkg::PL_W-1:0]  pl_s7 [3][2];
	logic        [tsg_pkg::DEN_W-1:0] den_s7;
	logic                             dz_s7;

	// stage 8 and 9: numerator assembly
	logic signed [tsg_pkg::NUM_W-1:0] part_s8 [3][2];
	logic        [tsg_pkg::DEN_W-1:0] den_s8;
	logic                             dz_s8;
	logic signed [tsg_pkg::NUM_W-1:0] num_s9 [3];
	logic        [tsg_pkg::DEN_W-1:0] den_s9;
	logic                             dz_s9;

	// operand split of the normal
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i]  = $signed(geo.n[i]);
			nh_c[i] = $signed(n_c[i][tsg_pkg::N_W-1:tsg_pkg::LO_W]);
			nl_c[i] = $signed({1'b0, n_c[i][tsg_pkg::LO_W-1:0]});
			ab_c[i] = $signed(geo.ab[i]);
			bc_c[i] = $signed(geo.bc[i]);
		end
	end

	// recombine partial products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = (tsg_pkg::SQ_W'(hh_s4[i]) <<< (2 * tsg_pkg::LO_W))
				+ (tsg_pkg::SQ_W'(hl_s4[i]) <<< (tsg_pkg::LO_W + 1))
				+ tsg_pkg::SQ_W'(ll_s4[i]);
			for (int t = 0; t < 4; t++) begin
				pf_c[i][t] = (tsg_pkg::NB_W'(xh_s4[i][t]) <<< tsg_pkg::LO_W)
					+ tsg_pkg::NB_W'(xl_s4[i][t]);
			end
		end
	end

	// chunks of N x ab and N x bc
	always_comb begin
		dp_c[0] = dpc_s6;
		dp_c[1] = dpa_s6;
		for (int i = 0; i < 3; i++) begin
			bh_c[i][0] = $signed(nab_s6[i][tsg_pkg::NB_W-1:2*tsg_pkg::LO_W]);
			bm_c[i][0] = $signed({1'b0, nab_s6[i][2*tsg_pkg::LO_W-1:tsg_pkg::LO_W]});
			bl_c[i][0] = $signed({1'b0, nab_s6[i][tsg_pkg::LO_W-1:0]});
			bh_c[i][1] = $signed(nbc_s6[i][tsg_pkg::NB_W-1:2*tsg_pkg::LO_W]);
			bm_c[i][1] = $signed({1'b0, nbc_s6[i][2*tsg_pkg::LO_W-1:tsg_pkg::LO_W]});
			bl_c[i][1] = $signed({1'b0, nbc_s6[i][tsg_pkg::LO_W-1:0]});
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s4 <= geo_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// stage 4
		for (int i = 0; i < 3; i++) begin
			hh_s4[i] <= nh_c[i] * nh_c[i];
			hl_s4[i] <= nh_c[i] * nl_c[i];
			ll_s4[i] <= n_c[i][tsg_pkg::LO_W-1:0] * n_c[i][tsg_pkg::LO_W-1:0];
			xh_s4[i][0] <= nh_c[tsg_pkg::NXT[i]] * ab_c[tsg_pkg::PRV[i]];
			xl_s4[i][0] <= nl_c[tsg_pkg::NXT[i]] * ab_c[tsg_pkg::PRV[i]];
			xh_s4[i][1] <= nh_c[tsg_pkg::PRV[i]] * ab_c[tsg_pkg::NXT[i]];
			xl_s4[i][1] <= nl_c[tsg_pkg::PRV[i]] * ab_c[tsg_pkg::NXT[i]];
			xh_s4[i][2] <= nh_c[tsg_pkg::NXT[i]] * bc_c[tsg_pkg::PRV[i]];
			xl_s4[i][2] <= nl_c[tsg_pkg::NXT[i]] * bc_c[tsg_pkg::PRV[i]];
			xh_s4[i][3] <= nh_c[tsg_pkg::PRV[i]] * bc_c[tsg_pkg::NXT[i]];
			xl_s4[i][3] <= nl_c[tsg_pkg::PRV[i]] * bc_c[tsg_pkg::NXT[i]];
		end
		dpc_s4 <= $signed(geo.dpc);
		dpa_s4 <= $signed(geo.dpa);

		// stage 5
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= sq_c[i][tsg_pkg::DEN_W-1:0];
			for (int t = 0; t < 4; t++) begin
				pf_s5[i][t] <= pf_c[i][t];
			end
		end
		dpc_s5 <= dpc_s4;
		dpa_s5 <= dpa_s4;

		// stage 6
		den_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
		for (int i = 0; i < 3; i++) begin
			nab_s6[i] <= pf_s5[i][0] - pf_s5[i][1];
			nbc_s6[i] <= pf_s5[i][2] - pf_s5[i][3];
		end
		dpc_s6 <= dpc_s5;
		dpa_s6 <= dpa_s5;

		// stage 7
		for (int i = 0; i < 3; i++) begin
			for (int m = 0; m < 2; m++) begin
				ph_s7[i][m] <= bh_c[i][m] * dp_c[m];
				pm_s7[i][m] <= bm_c[i][m] * dp_c[m];
				pl_s7[i][m] <= bl_c[i][m] * dp_c[m];
			end
		end
		den_s7 <= den_s6;
		dz_s7  <= (den_s6 == '0);

		// stage 8
		for (int i = 0; i < 3; i++) begin
			for (int m = 0; m < 2; m++) begin
				part_s8[i][m] <= (tsg_pkg::NUM_W'(ph_s7[i][m]) <<< (2 * tsg_pkg::LO_W))
					+ (tsg_pkg::NUM_W'(pm_s7[i][m]) <<< tsg_pkg::LO_W)
					+ tsg_pkg::NUM_W'(pl_s7[i][m]);
			end
		end
		den_s8 <= den_s7;
		dz_s8  <= dz_s7;

		// stage 9
		for (int i = 0; i < 3; i++) begin
			num_s9[i] <= part_s8[i][0] + part_s8[i][1];
		end
		den_s9 <= den_s8;
		dz_s9  <= dz_s8;
	end

	// hand over to the divider
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo.num[i] = num_s9[i];
		end
		quo.den = den_s9;
		quo.dz  = dz_s9;
	end

	assign quo_vld = vld_s9;

endmodule

// File: rtl/tsg_div.sv
// ----------------------------------------------------------------------------
// tsg_div
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing the denominator, followed by sign restore and saturation.
// ----------------------------------------------------------------------------
module tsg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              quo_vld,
	input  tsg_pkg::quo_t     quo,
	output logic              done,
	output tsg_pkg::result_t  result
);

	localparam int QW = tsg_pkg::Q_W;

	logic signed [tsg_pkg::NUM_W-1:0] num_c [3];
	logic        [tsg_pkg::NUM_W-1:0] abs_c [3];

	// magnitude stage
	logic                             vld_sa;
	logic                             neg_sa [3];
	logic        [tsg_pkg::MAG_W-1:0] mag_sa [3];
	logic        [tsg_pkg::DEN_W-1:0] den_sa;
	logic                             dz_sa;

	// overflow check and quotient bit stages, index is the stage
	logic                             vld_s [QW+1];
	logic        [tsg_pkg::CMP_W-1:0] rem_s [QW+1][3];
	logic        [QW-1:0]             qb_s  [QW+1][3];
	logic                             neg_s [QW+1][3];
	logic                             ovf_s [QW+1][3];
	logic        [tsg_pkg::DEN_W-1:0] den_s [QW+1];
	logic                             dz_s  [QW+1];

	logic        [tsg_pkg::CMP_W-1:0] dsh_c [QW];
	logic                             ge_c  [QW][3];

	// output register
	logic                             done_q;
	tsg_pkg::result_t                 result_q;

	logic        [QW-1:0]             lim_c  [3];
	logic                             clip_c [3];
	logic signed [tsg_pkg::IN_W-1:0]  val_c  [3];
	logic                             any_clip_c;

	// absolute value of the numerator
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = $signed(quo.num[i]);
			abs_c[i] = num_c[i][tsg_pkg::NUM_W-1] ? tsg_pkg::NUM_W'(-num_c[i])
				: tsg_pkg::NUM_W'(num_c[i]);
		end
	end

	// trial subtraction per stage
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			dsh_c[k] = tsg_pkg::CMP_W'(den_s[k]) << (QW - 1 - k);
			for (int i = 0; i < 3; i++) begin
				ge_c[k][i] = (rem_s[k][i] >= dsh_c[k]);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
			for (int k = 0; k <= QW; k++) begin
				vld_s[k] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_sa   <= quo_vld;
			vld_s[0] <= vld_sa;
			for (int k = 0; k < QW; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			done_q <= vld_s[QW];
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		// magnitude, scaled by the fraction bits
		for (int i = 0; i < 3; i++) begin
			neg_sa[i] <= num_c[i][tsg_pkg::NUM_W-1];
			mag_sa[i] <= tsg_pkg::MAG_W'(abs_c[i]) << tsg_pkg::FRAC_BITS;
		end
		den_sa <= quo.den;
		dz_sa  <= quo.dz;

		// quotient needs more than QW bits
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i] <= tsg_pkg::CMP_W'(mag_sa[i]);
			qb_s[0][i]  <= '0;
			neg_s[0][i] <= neg_sa[i];
			ovf_s[0][i] <= (tsg_pkg::CMP_W'(mag_sa[i]) >= (tsg_pkg::CMP_W'(den_sa) << QW));
		end
		den_s[0] <= den_sa;
		dz_s[0]  <= dz_sa;

		// one quotient bit per stage, most significant first
		for (int k = 0; k < QW; k++) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[k+1][i] <= ge_c[k][i] ? rem_s[k][i] - dsh_c[k] : rem_s[k][i];
				qb_s[k+1][i]  <= {qb_s[k][i][QW-2:0], ge_c[k][i]};
				neg_s[k+1][i] <= neg_s[k][i];
				ovf_s[k+1][i] <= ovf_s[k][i];
			end
			den_s[k+1] <= den_s[k];
			dz_s[k+1]  <= dz_s[k];
		end
	end

	// sign restore and saturation
	always_comb begin
		any_clip_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			lim_c[i]  = neg_s[QW][i] ? tsg_pkg::LIM_NEG : tsg_pkg::LIM_POS;
			clip_c[i] = ovf_s[QW][i] || (qb_s[QW][i] > lim_c[i]);
			if (clip_c[i]) begin
				val_c[i] = neg_s[QW][i] ? tsg_pkg::RES_MIN : tsg_pkg::RES_MAX;
			end else if (neg_s[QW][i]) begin
				val_c[i] = -$signed(qb_s[QW][i][tsg_pkg::IN_W-1:0]);
			end else begin
				val_c[i] = $signed(qb_s[QW][i][tsg_pkg::IN_W-1:0]);
			end
			any_clip_c = any_clip_c | clip_c[i];
		end
	end

	// result register, zero area forces a zero vector
	always_ff @(posedge clk) begin
		result_q.grad_x     <= dz_s[QW] ? '0 : val_c[0];
		result_q.grad_y     <= dz_s[QW] ? '0 : val_c[1];
		result_q.grad_z     <= dz_s[QW] ? '0 : val_c[2];
		result_q.degenerate <= dz_s[QW];
		result_q.saturated  <= !dz_s[QW] && any_clip_c;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/triangle_surface_gradient_top.sv
// Register stages: 3 geometry, 6 product, 36 divider and output stages; the
// result is valid while done is high. Throughput: one transaction per clock;
// busy stays low and start may be high in every cycle. The divider works one
// quotient bit per stage per lane. Reset clears all valid bits at once; the
// receiver cannot stall the output.
// ----------------------------------------------------------------------------
// triangle_surface_gradient_top
// Surface gradient of a linear potential over a triangle, signed Q16.16,
// truncated toward zero and saturated, with zero-area detection.
// ----------------------------------------------------------------------------
module triangle_surface_gradient_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tsg_pkg::item_t    item,
	output logic              busy,
	output logic              done,
	output tsg_pkg::result_t  result
);

	logic          geo_vld;
	tsg_pkg::geo_t geo;
	logic          quo_vld;
	tsg_pkg::quo_t quo;

	// fully pipelined, never holds off a transaction
	assign busy = 1'b0;

	// normal and edge vectors
	tsg_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start && !busy),
		.item    (item),
		.geo_vld (geo_vld),
		.geo     (geo)
	);

	// numerator and denominator
	tsg_proj u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.geo_vld (geo_vld),
		.geo     (geo),
		.quo_vld (quo_vld),
		.quo     (quo)
	);

	// division and saturation
	tsg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.quo_vld (quo_vld),
		.quo     (quo),
		.done    (done),
		.result  (result)
	);

	// every accepted transaction comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(tsg_pkg::PIPE_LAT) done)
		else $error("accepted transaction gave no result");

	// no result without an accepted transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, tsg_pkg::PIPE_LAT))
		else $error("result without a transaction");

	// zero area gives a zero vector and no saturation
	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> (result.grad_x == '0 && result.grad_y == '0
		&& result.grad_z == '0 && !result.saturated))
		else $error("degenerate result not cleared");

	// saturation leaves at least one component at a rail
	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |-> (result.grad_x == tsg_pkg::RES_MAX
		|| result.grad_x == tsg_pkg::RES_MIN || result.grad_y == tsg_pkg::RES_MAX
		|| result.grad_y == tsg_pkg::RES_MIN || result.grad_z == tsg_pkg::RES_MAX
		|| result.grad_z == tsg_pkg::RES_MIN))
		else $error("saturation flag without clipped component");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams triangles into the surface gradient pipeline, with directed corner
// cases first and then random triangles in bursts, and checks every result
// strobe against an exact wide-integer model of the gradient.
// ----------------------------------------------------------------------------
module testbench;

	localparam int N_RANDOM = 600;
	localparam int ONE      = 1 << tsg_pkg::FRAC_BITS;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		tsg_pkg::item_t   stim;
		bit               has_exp;
		tsg_pkg::result_t exp;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	tsg_pkg::item_t   item = '0;
	logic             busy;
	logic             done;
	tsg_pkg::result_t result;

	tsg_pkg::result_t grad_queue[$];
	int               n_errors = 0;

	triangle_surface_gradient_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	// clock
	always #10 clk = ~clk;

	// exact gradient of one triangle
	function automatic tsg_pkg::result_t surface_gradient(tsg_pkg::item_t t);
		wide_t   ab[3], bc[3], nrm[3], nab[3], nbc[3];
		wide_t   den, dpc, dpa, num, mag, q;
		wide_t   lim;
		bit      neg;
		int      j, k;
		tsg_pkg::result_t r;
		logic signed [tsg_pkg::IN_W-1:0] g[3];
		ab[0] = wide_t'(t.b_x) - wide_t'(t.a_x);
		ab[1] = wide_t'(t.b_y) - wide_t'(t.a_y);
		ab[2] = wide_t'(t.b_z) - wide_t'(t.a_z);
		bc[0] = wide_t'(t.c_x) - wide_t'(t.b_x);
		bc[1] = wide_t'(t.c_y) - wide_t'(t.b_y);
		bc[2] = wide_t'(t.c_z) - wide_t'(t.b_z);
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			nrm[i] = ab[j] * bc[k] - ab[k] * bc[j];
		end
		den = nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2];
		r = '0;
		if (den == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			nab[i] = nrm[j] * ab[k] - nrm[k] * ab[j];
			nbc[i] = nrm[j] * bc[k] - nrm[k] * bc[j];
		end
		dpc = wide_t'(t.pot_c) - wide_t'(t.pot_b);
		dpa = wide_t'(t.pot_a) - wide_t'(t.pot_b);
		for (int i = 0; i < 3; i++) begin
			num = (dpc * nab[i] + dpa * nbc[i]) <<< tsg_pkg::FRAC_BITS;
			neg = num < 0;
			mag = neg ? -num : num;
			q   = mag / den;
			lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7FFF_FFFF);
			if (q > lim) begin
				r.saturated = 1'b1;
				g[i] = neg ? tsg_pkg::RES_MIN : tsg_pkg::RES_MAX;
			end else begin
				g[i] = neg ? tsg_pkg::IN_W'(-q) : tsg_pkg::IN_W'(q);
			end
		end
		r.grad_x = g[0];
		r.grad_y = g[1];
		r.grad_z = g[2];
		return r;
	endfunction

	function automatic logic signed [tsg_pkg::IN_W-1:0] rnd_word();
		return $urandom;
	endfunction

	function automatic logic signed [tsg_pkg::IN_W-1:0] rnd_small();
		return $signed($urandom_range(8 * ONE)) - 4 * ONE;
	endfunction

	// random triangle of a given flavour
	function automatic tsg_pkg::item_t random_triangle(int unsigned flavour);
		tsg_pkg::item_t t;
		logic signed [tsg_pkg::IN_W-1:0] dx, dy, dz;
		t = {rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
			rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()};
		case (flavour)
			// mesh-sized triangle with moderate potentials
			0, 1, 2: begin
				t.a_x = rnd_small(); t.a_y = rnd_small(); t.a_z = rnd_small();
				t.b_x = rnd_small(); t.b_y = rnd_small(); t.b_z = rnd_small();
				t.c_x = rnd_small(); t.c_y = rnd_small(); t.c_z = rnd_small();
				t.pot_a = rnd_small(); t.pot_b = rnd_small(); t.pot_c = rnd_small();
			end
			// tiny triangle, full-range potentials: drives saturation
			3: begin
				t.a_x = $urandom_range(15); t.a_y = $urandom_range(15);
				t.a_z = $urandom_range(15);
				t.b_x = t.a_x + $urandom_range(3); t.b_y = t.a_y + $urandom_range(3);
				t.b_z = t.a_z;
				t.c_x = t.a_x; t.c_y = t.a_y + $urandom_range(3);
				t.c_z = t.a_z + $urandom_range(3);
			end
			// collinear or coincident vertices: zero area
			4: begin
				dx = $signed($urandom_range(64)) - 32;
				dy = $signed($urandom_range(64)) - 32;
				dz = $signed($urandom_range(64)) - 32;
				t.a_x = rnd_small(); t.a_y = rnd_small(); t.a_z = rnd_small();
				t.b_x = t.a_x + dx; t.b_y = t.a_y + dy; t.b_z = t.a_z + dz;
				t.c_x = t.b_x + dx * 3; t.c_y = t.b_y + dy * 3; t.c_z = t.b_z + dz * 3;
			end
			// anything else stays full-range random
			default: ;
		endcase
		return t;
	endfunction

	// directed triangles
	function automatic row_t mk(tsg_pkg::item_t t, bit has_exp = 1'b0,
		tsg_pkg::result_t e = '0);
		row_t r;
		r.stim = t;
		r.has_exp = has_exp;
		r.exp = e;
		return r;
	endfunction

	function automatic tsg_pkg::item_t tri_of(
		int ax, int ay, int az, int bx, int by, int bz, int cx, int cy, int cz,
		int pa, int pb, int pc);
		return {ax, ay, az, bx, by, bz, cx, cy, cz, pa, pb, pc};
	endfunction

	// accepted transaction: record what it should produce
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			grad_queue = {grad_queue, surface_gradient(item)};
	end

	task automatic check_field(string name, logic [tsg_pkg::IN_W-1:0] e,
		logic [tsg_pkg::IN_W-1:0] g);
		if (e !== g) begin
			n_errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, g);
		end
	endtask

	// result strobe: compare with the oldest expectation
	always @(posedge clk) begin
		tsg_pkg::result_t e;
		if (arst_n && done) begin
			if (grad_queue.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
			end else begin
				e = grad_queue.pop_front();
				check_field("grad_x", e.grad_x, result.grad_x);
				check_field("grad_y", e.grad_y, result.grad_y);
				check_field("grad_z", e.grad_z, result.grad_z);
				check_field("degenerate", tsg_pkg::IN_W'(e.degenerate),
					tsg_pkg::IN_W'(result.degenerate));
				check_field("saturated", tsg_pkg::IN_W'(e.saturated),
					tsg_pkg::IN_W'(result.saturated));
			end
		end
	end

	// present one transaction and hold it until taken
	task automatic send(tsg_pkg::item_t t);
		start <= 1'b1;
		item  <= t;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// watchdog
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus
	initial begin
		row_t             rows[$];
		tsg_pkg::result_t e;
		int               burst;
		int               gap;
		int               sent;
		bit               drained;

		// typed-in corners
		e = '0; e.degenerate = 1'b1;
		rows = {rows, mk('0, 1'b1, e)};
		rows = {rows, mk(tri_of(5, 5, 5, 5, 5, 5, 5, 5, 5, 1, 2, 3), 1'b1, e)};
		rows = {rows, mk({12{tsg_pkg::RES_MAX}}, 1'b1, e)};
		rows = {rows, mk({12{tsg_pkg::RES_MIN}}, 1'b1, e)};
		// unit right triangle, potential equal to x
		e = '0; e.grad_x = ONE;
		rows = {rows, mk(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 0), 1'b1, e)};
		// same triangle, potential equal to y
		e = '0; e.grad_y = ONE;
		rows = {rows, mk(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, e)};
		// flat potential gives zero gradient
		e = '0;
		rows = {rows, mk(tri_of(0, 0, 0, ONE, 0, 0, 0, 0, ONE, 7, 7, 7), 1'b1, e)};
		// smallest triangle, largest potential step: clips high and low
		e = '0; e.grad_x = tsg_pkg::RES_MAX; e.saturated = 1'b1;
		rows = {rows, mk(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, tsg_pkg::RES_MAX, 0),
			1'b1, e)};
		e = '0; e.grad_x = tsg_pkg::RES_MIN; e.saturated = 1'b1;
		rows = {rows, mk(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, tsg_pkg::RES_MAX,
			tsg_pkg::RES_MIN, tsg_pkg::RES_MAX), 1'b1, e)};
		// extremes checked by the model
		rows = {rows, mk({tsg_pkg::RES_MIN, tsg_pkg::RES_MIN, tsg_pkg::RES_MIN,
			tsg_pkg::RES_MAX, tsg_pkg::RES_MIN, tsg_pkg::RES_MIN,
			tsg_pkg::RES_MIN, tsg_pkg::RES_MAX, tsg_pkg::RES_MIN,
			tsg_pkg::RES_MAX, tsg_pkg::RES_MIN, tsg_pkg::RES_MAX})};
		rows = {rows, mk({tsg_pkg::RES_MAX, tsg_pkg::RES_MIN, tsg_pkg::RES_MAX,
			tsg_pkg::RES_MIN, tsg_pkg::RES_MAX, tsg_pkg::RES_MIN,
			tsg_pkg::RES_MAX, tsg_pkg::RES_MAX, tsg_pkg::RES_MIN,
			tsg_pkg::RES_MIN, tsg_pkg::RES_MAX, tsg_pkg::RES_MIN})};
		rows = {rows, mk({tsg_pkg::RES_MIN, tsg_pkg::RES_MIN, tsg_pkg::RES_MIN,
			tsg_pkg::RES_MAX, tsg_pkg::RES_MAX, tsg_pkg::RES_MAX,
			tsg_pkg::RES_MIN, tsg_pkg::RES_MAX, tsg_pkg::RES_MAX,
			tsg_pkg::RES_MIN, tsg_pkg::RES_MAX, tsg_pkg::RES_MIN})};
		rows = {rows, mk(tri_of(-ONE, 0, 0, ONE, 0, 0, 0, 3 * ONE, ONE, -5 * ONE, ONE,
			9))};
		rows = {rows, mk(tri_of(0, 0, 0, 3, 0, 0, 0, 0, 5, 123456, -98765, 4242))};
		// division with a remainder, truncated towards zero on negative values
		rows = {rows, mk(tri_of(0, 0, 0, 3 * ONE, 0, 0, 0, 7 * ONE, 0, 0, -1, 1))};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (rows[i]) begin
			send(rows[i].stim);
			if (rows[i].has_exp && surface_gradient(rows[i].stim) !== rows[i].exp) begin
				n_errors++;
				$display("%0t: directed row %0d model disagrees: expected %h, actual %h",
					$time, i, rows[i].exp, surface_gradient(rows[i].stim));
			end
		end

		// random bursts with gaps
		sent = 0;
		drained = 1'b0;
		while (sent < N_RANDOM) begin
			if (!drained && sent >= N_RANDOM / 2) begin
				// let the pipeline drain completely once
				drained = 1'b1;
				start <= 1'b0;
				@(posedge clk);
				while (grad_queue.size() != 0) @(posedge clk);
			end
			burst = $urandom_range(40, 1);
			for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
				send(random_triangle($urandom_range(6)));
				sent++;
			end
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(5);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;

		// drain
		while (grad_queue.size() != 0) @(posedge clk);
		repeat (tsg_pkg::PIPE_LAT + 10) @(posedge clk);
		if (grad_queue.size() != 0) n_errors++;
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
